[design/mf3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and helpers of the clipped-edge 3x3 mean filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_DIM     = 16;
    localparam int PIX_W       = 8;
    localparam int SIZE_W      = 5;
    localparam int ROW_W       = $clog2(MAX_DIM);
    localparam int SLOT_W      = 2;
    localparam int ADDR_W      = SLOT_W + ROW_W;
    localparam int STORE_DEPTH = 3 * MAX_DIM;
    localparam int NJOBS       = 4;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 15;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(16);
    localparam logic [SIZE_W-1:0]  SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0]  SIZE_MAX   = SIZE_W'(MAX_DIM);

    // reciprocals scaled by 2^16
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(16384);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(10923);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

    // job bits: above-left, above-last-col, current-left, current-last-col
    localparam int JOB_UL = 0;
    localparam int JOB_UE = 1;
    localparam int JOB_CL = 2;
    localparam int JOB_CE = 3;

    typedef enum logic [1:0] {
        WIN_4,
        WIN_6,
        WIN_9
    } win_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PICK,
        BK_READ,
        BK_DRAIN,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [NJOBS-1:0] jobs;
    } q_entry_t;

    function automatic logic [SLOT_W-1:0] row_slot(input logic [ROW_W-1:0] y);
        logic [SLOT_W-1:0] s;
        case (y)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: s = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       s = 2'd1;
            default:                              s = 2'd2;
        endcase
        return s;
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input win_kind_t k);
        logic [RECIP_W-1:0] r;
        case (k)
            WIN_4:   r = RECIP_4;
            WIN_6:   r = RECIP_6;
            WIN_9:   r = RECIP_9;
            default: r = RECIP_4;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[design/mean_filter_3x3_clipped_edges_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mean_filter_3x3_clipped_edges_top
// Streaming 3x3 mean filter over a square 8-bit image, window clipped at edges.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_wr_data set the image size (2..16, clamped) and restart the
//   position at pixel (0,0). Write it only while the block is idle.
//   s_valid/s_ready/s_pixel carry one pixel per item in row-major order.
//   m_valid/m_ready carry the smoothed pixels with their row and column;
//   m_burst_end marks the last result caused by one input item.
// Back end:
//   An item with no result passes the back end through PICK and back to IDLE.
//   Each result passes PICK, READ, DRAIN, DIV and OUT; READ fetches its k = 4,
//   6 or 9 window pixels in turn through the single read port of the line
//   store. An item gives 0 to 4 results; each is valid once OUT is left.
//   A two-item queue lets input be taken while the back end works.
// Reset: position, size (16), queue and output valid are cleared.
// Receiver stall: the output register holds; the back end, then the queue,
//   then s_ready stop in turn. No item is lost.
// ----------------------------------------------------------------------------
module mean_filter_3x3_clipped_edges_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [mf3_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mf3_pkg::PIX_W-1:0]   s_pixel,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mf3_pkg::PIX_W-1:0]        m_value,
    output logic [mf3_pkg::ROW_W-1:0]        m_out_row,
    output logic [mf3_pkg::ROW_W-1:0]        m_out_col,
    output logic                             m_burst_end
);
    import mf3_pkg::*;

    q_entry_t          q_in, q_head;
    logic              q_push, q_full, q_pop, q_empty;
    logic [ROW_W-1:0]  n_m1;

    mf3_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .q_push      (q_push),
        .q_entry     (q_in),
        .q_full      (q_full),
        .n_m1        (n_m1)
    );

    mf3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    mf3_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .n_m1        (n_m1),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_burst_end (m_burst_end)
    );

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("back end took an item from an empty queue");

    a_above_jobs: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.jobs[JOB_UE]) |-> q_head.jobs[JOB_UL])
        else $error("row-end job above without its left neighbour job");

    a_last_row_jobs: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.jobs[JOB_CL]) |-> (q_head.row == n_m1))
        else $error("current-row job outside the last row");

endmodule
`default_nettype wire

[design/mf3_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_front
// Holds the size register and input position, tags each item with its jobs.
// ----------------------------------------------------------------------------
module mf3_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [mf3_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mf3_pkg::PIX_W-1:0]   s_pixel,
    output logic                             q_push,
    output mf3_pkg::q_entry_t                q_entry,
    input  wire logic                        q_full,
    output logic [mf3_pkg::ROW_W-1:0]        n_m1
);
    import mf3_pkg::*;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  col_reg, col_next;
    logic [SIZE_W-1:0] size_eff;
    logic [ROW_W-1:0]  cur_row, cur_col;
    logic              accept;

    always_comb begin
        if (size_reg < SIZE_MIN) begin
            size_eff = SIZE_MIN;
        end else if (size_reg > SIZE_MAX) begin
            size_eff = SIZE_MAX;
        end else begin
            size_eff = size_reg;
        end
        n_m1 = ROW_W'(size_eff - SIZE_W'(1));
    end

    always_comb begin
        if (row_reg > n_m1 || col_reg > n_m1) begin
            cur_row = '0;
            cur_col = '0;
        end else begin
            cur_row = row_reg;
            cur_col = col_reg;
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign q_push  = accept;

    always_comb begin
        q_entry.pixel        = s_pixel;
        q_entry.row          = cur_row;
        q_entry.col          = cur_col;
        q_entry.jobs[JOB_UL] = (cur_row != '0) && (cur_col != '0);
        q_entry.jobs[JOB_UE] = q_entry.jobs[JOB_UL] && (cur_col == n_m1);
        q_entry.jobs[JOB_CL] = (cur_row == n_m1) && (cur_col != '0);
        q_entry.jobs[JOB_CE] = q_entry.jobs[JOB_CL] && (cur_col == n_m1);
    end

    always_comb begin
        size_next = size_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (cfg_wr_en) begin
            size_next = cfg_wr_data;
            row_next  = '0;
            col_next  = '0;
        end else if (accept) begin
            if (cur_col == n_m1) begin
                col_next = '0;
                row_next = (cur_row == n_m1) ? '0 : cur_row + ROW_W'(1);
            end else begin
                col_next = cur_col + ROW_W'(1);
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
        end else begin
            size_reg <= size_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

endmodule
`default_nettype wire

[design/mf3_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_queue
// Two-entry queue of tagged items between front and back.
// ----------------------------------------------------------------------------
module mf3_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire mf3_pkg::q_entry_t push_entry,
    output logic                   full,
    input  wire logic              pop,
    output mf3_pkg::q_entry_t      head,
    output logic                   empty
);
    import mf3_pkg::*;

    q_entry_t            entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[design/mf3_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_back
// Line store, window summation, reciprocal division and output register.
// ----------------------------------------------------------------------------
module mf3_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [mf3_pkg::ROW_W-1:0]   n_m1,
    input  wire mf3_pkg::q_entry_t           q_head,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mf3_pkg::PIX_W-1:0]        m_value,
    output logic [mf3_pkg::ROW_W-1:0]        m_out_row,
    output logic [mf3_pkg::ROW_W-1:0]        m_out_col,
    output logic                             m_burst_end
);
    import mf3_pkg::*;

    back_state_t         state_reg, state_next;
    logic [PIX_W-1:0]    store [STORE_DEPTH];
    logic [PIX_W-1:0]    rdata_reg;
    logic                rd_pend_reg, rd_pend_next;

    logic [ROW_W-1:0]    item_row_reg, item_row_next;
    logic [ROW_W-1:0]    item_col_reg, item_col_next;
    logic [NJOBS-1:0]    jobs_reg, jobs_next;
    logic [ROW_W-1:0]    job_row_reg, job_row_next;
    logic [ROW_W-1:0]    job_col_reg, job_col_next;
    logic                last_reg, last_next;
    win_kind_t           kind_reg, kind_next;
    logic [ROW_W-1:0]    y_reg, y_next;
    logic [ROW_W-1:0]    x_reg, x_next;
    logic [ROW_W-1:0]    r1_reg, r1_next;
    logic [ROW_W-1:0]    c0_reg, c0_next;
    logic [ROW_W-1:0]    c1_reg, c1_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]    m_value_reg, m_value_next;
    logic [ROW_W-1:0]    m_row_reg, m_row_next;
    logic [ROW_W-1:0]    m_col_reg, m_col_next;
    logic                m_end_reg, m_end_next;

    logic                out_free;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic                read_done;
    logic [ROW_W-1:0]    r_sel, c_sel;
    logic [NJOBS-1:0]    jobs_left;
    logic                rows3, cols3;

    assign out_free  = !m_valid_reg || m_ready;
    assign wr_addr   = {row_slot(q_head.row), q_head.col};
    assign rd_addr   = {row_slot(y_reg), x_reg};
    assign read_done = (x_reg == c1_reg) && (y_reg == r1_reg);

    // next job, lowest pending bit first
    always_comb begin
        r_sel     = item_row_reg;
        c_sel     = n_m1;
        jobs_left = jobs_reg;
        if (jobs_reg[JOB_UL]) begin
            r_sel             = item_row_reg - ROW_W'(1);
            c_sel             = item_col_reg - ROW_W'(1);
            jobs_left[JOB_UL] = 1'b0;
        end else if (jobs_reg[JOB_UE]) begin
            r_sel             = item_row_reg - ROW_W'(1);
            c_sel             = n_m1;
            jobs_left[JOB_UE] = 1'b0;
        end else if (jobs_reg[JOB_CL]) begin
            r_sel             = item_row_reg;
            c_sel             = item_col_reg - ROW_W'(1);
            jobs_left[JOB_CL] = 1'b0;
        end else begin
            r_sel             = item_row_reg;
            c_sel             = n_m1;
            jobs_left[JOB_CE] = 1'b0;
        end
        rows3 = (r_sel != '0) && (r_sel != n_m1);
        cols3 = (c_sel != '0) && (c_sel != n_m1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = BK_PICK;
                end
            end
            BK_PICK: begin
                state_next = (jobs_reg == '0) ? BK_IDLE : BK_READ;
            end
            BK_READ: begin
                if (read_done) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: state_next = BK_DIV;
            BK_DIV:   state_next = BK_OUT;
            BK_OUT: begin
                if (out_free) begin
                    state_next = BK_PICK;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        rd_pend_next  = 1'b0;
        item_row_next = item_row_reg;
        item_col_next = item_col_reg;
        jobs_next     = jobs_reg;
        job_row_next  = job_row_reg;
        job_col_next  = job_col_reg;
        last_next     = last_reg;
        kind_next     = kind_reg;
        y_next        = y_reg;
        x_next        = x_reg;
        r1_next       = r1_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        sum_next      = rd_pend_reg ? sum_reg + SUM_W'(rdata_reg) : sum_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        m_value_next  = m_value_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        m_end_next    = m_end_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop         = 1'b1;
                    mem_we        = 1'b1;
                    item_row_next = q_head.row;
                    item_col_next = q_head.col;
                    jobs_next     = q_head.jobs;
                end
            end
            BK_PICK: begin
                if (jobs_reg != '0) begin
                    jobs_next    = jobs_left;
                    last_next    = (jobs_left == '0);
                    job_row_next = r_sel;
                    job_col_next = c_sel;
                    y_next       = (r_sel != '0) ? r_sel - ROW_W'(1) : r_sel;
                    r1_next      = (r_sel != n_m1) ? r_sel + ROW_W'(1) : r_sel;
                    c0_next      = (c_sel != '0) ? c_sel - ROW_W'(1) : c_sel;
                    c1_next      = (c_sel != n_m1) ? c_sel + ROW_W'(1) : c_sel;
                    x_next       = c0_next;
                    sum_next     = '0;
                    if (rows3 && cols3) begin
                        kind_next = WIN_9;
                    end else if (rows3 || cols3) begin
                        kind_next = WIN_6;
                    end else begin
                        kind_next = WIN_4;
                    end
                end
            end
            BK_READ: begin
                rd_pend_next = 1'b1;
                if (x_reg == c1_reg) begin
                    x_next = c0_reg;
                    if (!read_done) begin
                        y_next = y_reg + ROW_W'(1);
                    end
                end else begin
                    x_next = x_reg + ROW_W'(1);
                end
            end
            BK_DRAIN: begin
            end
            BK_DIV: begin
                prod_next = PROD_W'(sum_reg) * PROD_W'(recip(kind_reg));
            end
            BK_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = prod_reg[16 +: PIX_W];
                    m_row_next   = job_row_reg;
                    m_col_next   = job_col_reg;
                    m_end_next   = last_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[wr_addr] <= q_head.pixel;
        end
        rdata_reg <= store[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_row_reg <= item_row_next;
        item_col_reg <= item_col_next;
        jobs_reg     <= jobs_next;
        job_row_reg  <= job_row_next;
        job_col_reg  <= job_col_next;
        last_reg     <= last_next;
        kind_reg     <= kind_next;
        y_reg        <= y_next;
        x_reg        <= x_next;
        r1_reg       <= r1_next;
        c0_reg       <= c0_next;
        c1_reg       <= c1_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        m_value_reg  <= m_value_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_end_reg    <= m_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_burst_end = m_end_reg;

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clipped-edge 3x3 mean filter. Pixels go in as
// whole and partial square images of many sizes. An own model of the line
// store and the output schedule predicts every smoothed pixel with its row,
// column and burst end. Both handshakes idle at random, and one long receiver
// hold-off fills the block.
// ----------------------------------------------------------------------------
module testbench;
    import mf3_pkg::*;

    localparam int ITEM_TARGET   = 250;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             last;
    } smooth_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0]   cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [PIX_W-1:0]    s_pixel     = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [PIX_W-1:0]    m_value;
    logic [ROW_W-1:0]    m_out_row;
    logic [ROW_W-1:0]    m_out_col;
    logic                m_burst_end;

    // predictor state
    logic [PIX_W-1:0]    rows_held [3][MAX_DIM];
    logic [SIZE_W-1:0]   size_reg = SIZE_RESET;
    int unsigned         cur_row = 0;
    int unsigned         cur_col = 0;
    smooth_t             smooth_q[$];

    int unsigned         pixels_sent  = 0;
    int unsigned         mismatches   = 0;
    int unsigned         quiet_cycles = 0;
    bit                  tx_idle      = 1'b0;
    bit                  rx_idle      = 1'b0;
    int unsigned         hold_req     = 0;
    int unsigned         hold_seen    = 0;
    int unsigned         rx_wait      = 0;

    mean_filter_3x3_clipped_edges_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_burst_end (m_burst_end)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 19) < 16)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned side_len();
        if (size_reg < SIZE_MIN)
            return SIZE_MIN;
        if (size_reg > SIZE_MAX)
            return SIZE_MAX;
        return size_reg;
    endfunction

    // truncated mean of the window clipped to the image
    function automatic void queue_smoothed(int unsigned r, int unsigned c, int unsigned n);
        int unsigned r0, r1, c0, c1, sum, cnt;
        smooth_t     res;
        r0  = (r > 0) ? r - 1 : r;
        r1  = (r + 1 < n) ? r + 1 : r;
        c0  = (c > 0) ? c - 1 : c;
        c1  = (c + 1 < n) ? c + 1 : c;
        sum = 0;
        cnt = 0;
        for (int unsigned y = r0; y <= r1; y++) begin
            for (int unsigned x = c0; x <= c1; x++) begin
                sum += rows_held[y % 3][x];
                cnt++;
            end
        end
        res.value = PIX_W'(sum / cnt);
        res.row   = ROW_W'(r);
        res.col   = ROW_W'(c);
        res.last  = 1'b0;
        smooth_q.push_back(res);
    endfunction

    function automatic void absorb_pixel(logic [PIX_W-1:0] pix);
        int unsigned n, i, j, prior;
        n     = side_len();
        i     = cur_row;
        j     = cur_col;
        prior = smooth_q.size();
        if (i >= n || j >= n) begin
            i = 0;
            j = 0;
        end
        rows_held[i % 3][j] = pix;
        if (i >= 1 && j >= 1) begin
            queue_smoothed(i - 1, j - 1, n);
            if (j == n - 1)
                queue_smoothed(i - 1, n - 1, n);
        end
        if (i == n - 1 && j >= 1) begin
            queue_smoothed(i, j - 1, n);
            if (j == n - 1)
                queue_smoothed(i, n - 1, n);
        end
        if (smooth_q.size() > prior)
            smooth_q[smooth_q.size() - 1].last = 1'b1;
        j++;
        if (j >= n) begin
            j = 0;
            i = (i + 1 >= n) ? 0 : i + 1;
        end
        cur_row = i;
        cur_col = j;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = (tx_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
        absorb_pixel(pix);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (smooth_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // only while idle
    task automatic write_size(input logic [SIZE_W-1:0] sz);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sz;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        size_reg = sz;
        cur_row  = 0;
        cur_col  = 0;
    endtask

    task automatic test_reset_size();
        send_pixel('0);
        send_pixel('1);
        wait_drained();
    endtask

    task automatic test_size_clamp_low();
        write_size(SIZE_W'(0));
        repeat (4) send_pixel('1);
        wait_drained();
        write_size(SIZE_W'(1));
        send_pixel('0);
        send_pixel('1);
        send_pixel('1);
        send_pixel('0);
        wait_drained();
    endtask

    task automatic test_restart_mid_image();
        write_size(SIZE_W'(3));
        repeat (4) send_pixel(rand_pixel());
        wait_drained();
        write_size(SIZE_W'(3));
        for (int k = 0; k < 9; k++)
            send_pixel((k % 2 == 0) ? '1 : '0);
        wait_drained();
    endtask

    task automatic test_size_clamp_high();
        write_size(SIZE_W'(31));
        send_pixel('1);
        send_pixel('0);
        wait_drained();
    endtask

    // receiver holds off while a 16-wide image streams in
    task automatic test_backpressure();
        write_size(SIZE_MAX);
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
        hold_req <= hold_req + 1;
        repeat (40) send_pixel(rand_pixel());
        wait_drained();
    endtask

    task automatic test_random_images();
        int unsigned pick, n, count;
        while (pixels_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                write_size(SIZE_W'($urandom_range(2, 6)));
            else if (pick == 7)
                write_size(SIZE_W'($urandom_range(0, 1)));
            else if (pick == 8)
                write_size(SIZE_W'($urandom_range(7, 16)));
            else
                write_size(SIZE_W'($urandom_range(16, 31)));
            n = side_len();
            if (n <= 6) begin
                count = n * n * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    count -= $urandom_range(1, n);
            end else begin
                count = n * $urandom_range(2, 3) + $urandom_range(0, n - 1);
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle <= ($urandom_range(0, 3) != 0);
            repeat (count) send_pixel(rand_pixel());
            wait_drained();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            rx_wait   <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rx_wait <= idle_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        smooth_t want;
        if (aresetn && m_valid && m_ready) begin
            if (smooth_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: value %0d row %0d col %0d end %0b",
                             m_value, m_out_row, m_out_col, m_burst_end);
            end else begin
                want = smooth_q.pop_front();
                if (m_value !== want.value || m_out_row !== want.row ||
                    m_out_col !== want.col || m_burst_end !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp value %0d row %0d col %0d end %0b,",
                                 want.value, want.row, want.col, want.last);
                        $display("          got value %0d row %0d col %0d end %0b",
                                 m_value, m_out_row, m_out_col, m_burst_end);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (rows_held[y, x])
            rows_held[y][x] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_size();
        test_size_clamp_low();
        test_restart_mid_image();
        test_size_clamp_high();
        test_backpressure();
        test_random_images();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
